/* design/sfd_pkg.sv */
// shared constants and types for the slip frame decoder
package sfd_pkg;

    localparam int FRAME_DEPTH_DEFAULT = 1024;

    localparam logic [7:0] BYTE_END     = 8'hC0;
    localparam logic [7:0] BYTE_ESC     = 8'hDB;
    localparam logic [7:0] BYTE_ESC_END = 8'hDC;
    localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

    localparam logic [15:0] ERR_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RECV = 3'b010,
        ST_ESC  = 3'b100
    } state_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  data_index;
        logic        frame_done;
        logic [10:0] frame_length;
        logic        bad_escape;
        logic        overflow;
    } result_t;

    typedef struct packed {
        logic [15:0] errors;
        logic [15:0] frames;
        logic [31:0] bytes;
    } counters_t;

endpackage

/* design/slip_frame_decoder.sv */
// slip receive decoder top level: input register, decode state and result register
//
// Decodes SLIP framing one line byte per item and accepts a new item every
// cycle while in_stall is low. An item is held in the input register, is
// decoded there against the current state and lands in the result register,
// where its result is presented and can be taken when out_stall is low.
// The state, frame position and running counters are updated when an item
// moves into the result register, and the totals shown always belong to the
// item in the result register. in_stall rises only when both the input and
// result registers are full and out_stall is high.
module slip_frame_decoder #(
    parameter int FRAME_DEPTH = sfd_pkg::FRAME_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  line_byte,
    input  logic        resync,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic [9:0]  data_index,
    output logic        frame_done,
    output logic [10:0] frame_length,
    output logic        bad_escape,
    output logic        overflow,
    output logic [15:0] error_total,
    output logic [15:0] frame_total,
    output logic [31:0] byte_total
);

    localparam int PW = $clog2(FRAME_DEPTH + 1);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_resync_reg;
    logic               out_valid_reg;
    sfd_pkg::result_t   res_reg;
    sfd_pkg::result_t   res_next;
    sfd_pkg::state_t    state_reg;
    sfd_pkg::state_t    state_next;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    sfd_pkg::counters_t cnt_reg;
    sfd_pkg::counters_t cnt_next;
    logic               out_ready;
    logic               advance;
    logic               in_take;

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    sfd_decode #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .PW          (PW)
    ) u_decode (
        .line_byte     (s1_byte_reg),
        .resync        (s1_resync_reg),
        .state         (state_reg),
        .position      (pos_reg),
        .counters      (cnt_reg),
        .state_next    (state_next),
        .position_next (pos_next),
        .counters_next (cnt_next),
        .result        (res_next)
    );

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= sfd_pkg::ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                pos_reg       <= pos_next;
                cnt_reg       <= cnt_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg   <= line_byte;
            s1_resync_reg <= resync;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_valid   = res_reg.data_valid;
    assign data_byte    = res_reg.data_byte;
    assign data_index   = res_reg.data_index;
    assign frame_done   = res_reg.frame_done;
    assign frame_length = res_reg.frame_length;
    assign bad_escape   = res_reg.bad_escape;
    assign overflow     = res_reg.overflow;
    assign error_total  = cnt_reg.errors;
    assign frame_total  = cnt_reg.frames;
    assign byte_total   = cnt_reg.bytes;

endmodule

/* design/sfd_decode.sv */
// per-item slip decode: next state, next position, next counters and result
module sfd_decode #(
    parameter int FRAME_DEPTH = sfd_pkg::FRAME_DEPTH_DEFAULT,
    parameter int PW          = $clog2(FRAME_DEPTH + 1)
) (
    input  logic [7:0]         line_byte,
    input  logic               resync,
    input  sfd_pkg::state_t    state,
    input  logic [PW-1:0]      position,
    input  sfd_pkg::counters_t counters,
    output sfd_pkg::state_t    state_next,
    output logic [PW-1:0]      position_next,
    output sfd_pkg::counters_t counters_next,
    output sfd_pkg::result_t   result
);

    logic [PW+10:0] pos_wide;
    logic           do_store;
    logic [7:0]     store_byte;
    logic [1:0]     err_inc;
    logic           frame_inc;
    logic           byte_inc;
    logic [16:0]    err_sum;

    assign pos_wide = {11'b0, position};

    always_comb
    begin
        state_next    = state;
        position_next = position;
        result        = '0;
        do_store      = 1'b0;
        store_byte    = line_byte;
        err_inc       = 2'd0;
        frame_inc     = 1'b0;
        byte_inc      = 1'b0;

        if (resync)
        begin
            state_next    = sfd_pkg::ST_IDLE;
            position_next = '0;
        end
        else
        begin
            byte_inc = 1'b1;
            unique case (state)
                sfd_pkg::ST_RECV:
                begin
                    if (line_byte == sfd_pkg::BYTE_END)
                    begin
                        if (position != '0)
                        begin
                            frame_inc           = 1'b1;
                            result.frame_done   = 1'b1;
                            result.frame_length = pos_wide[10:0];
                            state_next          = sfd_pkg::ST_IDLE;
                        end
                    end
                    else if (line_byte == sfd_pkg::BYTE_ESC)
                    begin
                        state_next = sfd_pkg::ST_ESC;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                sfd_pkg::ST_ESC:
                begin
                    state_next = sfd_pkg::ST_RECV;
                    do_store   = 1'b1;
                    if (line_byte == sfd_pkg::BYTE_ESC_END)
                    begin
                        store_byte = sfd_pkg::BYTE_END;
                    end
                    else if (line_byte == sfd_pkg::BYTE_ESC_ESC)
                    begin
                        store_byte = sfd_pkg::BYTE_ESC;
                    end
                    else
                    begin
                        err_inc           = 2'd1;
                        result.bad_escape = 1'b1;
                    end
                end
                default:
                begin
                    state_next = sfd_pkg::ST_IDLE;
                    if (line_byte == sfd_pkg::BYTE_END)
                    begin
                        position_next = '0;
                        state_next    = sfd_pkg::ST_RECV;
                    end
                end
            endcase

            if (do_store)
            begin
                if (position < PW'(FRAME_DEPTH))
                begin
                    result.data_valid = 1'b1;
                    result.data_byte  = store_byte;
                    result.data_index = pos_wide[9:0];
                    position_next     = PW'(position + 1'b1);
                end
                else
                begin
                    err_inc         = err_inc + 2'd1;
                    result.overflow = 1'b1;
                    state_next      = sfd_pkg::ST_IDLE;
                    position_next   = '0;
                end
            end
        end
    end

    // saturating error count, plain wrap for the others
    assign err_sum = {1'b0, counters.errors} + {15'b0, err_inc};

    always_comb
    begin
        counters_next.errors = err_sum[16] ? sfd_pkg::ERR_MAX : err_sum[15:0];
        counters_next.frames = counters.frames + {15'b0, frame_inc};
        counters_next.bytes  = counters.bytes + {31'b0, byte_inc};
    end

endmodule
